// ===== hdl/tpte_pkg.sv =====
// Shared types and constants for the two-level page table engine.
// No dependencies; tpte_store and the engine in hdl/ import this package, tpte_if does not.
package tpte_pkg;

    // Geometry of the translation structures
    localparam int unsigned DIR_ENTRIES     = 1024;
    localparam int unsigned IDX_W           = 10;
    localparam int unsigned FRAME_W         = 20;
    localparam int unsigned PAGE_SHIFT      = 12;
    localparam int unsigned DIR_SHIFT       = 22;
    localparam int unsigned TABLE_SLOTS_DEF = 16;

    // Commands; the fourth code does nothing
    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_XLATE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_DIR  = 2'd1,
        ST_NO_SLOT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_TAB
    } t_state;

    // Directory entry as stored: table address and present bit
    typedef struct packed {
        logic               present;
        logic [FRAME_W-1:0] addr;
    } t_dir_entry;

    // Table entry as stored: allocation mark at write time and the frame
    typedef struct packed {
        logic               mark;
        logic [FRAME_W-1:0] frame;
    } t_tab_entry;

    // Port strobes of the two memories
    typedef struct packed {
        logic dir_we;
        logic dir_re;
        logic tab_we;
        logic tab_re;
    } t_mem_ctl;

endpackage

// ===== hdl/tpte_if.sv =====
// Request and response channel interfaces of the page table engine.
// Plain valid/ready handshake; no dependency on the package.
interface tpte_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] page_flags;

    modport source (output valid, command, virt_addr, phys_addr, page_flags, input ready);
    modport sink   (input valid, command, virt_addr, phys_addr, page_flags, output ready);
endinterface

interface tpte_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] phys_frame;
    logic [1:0]  status;

    modport source (output valid, phys_frame, status, input ready);
    modport sink   (input valid, phys_frame, status, output ready);
endinterface

// ===== hdl/tpte_store.sv =====
// Page directory and table pool memories, registered synchronous read.
// Depends on tpte_pkg for entry types and the port strobe struct.
module tpte_store
    import tpte_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF,
    localparam int unsigned TAB_DEPTH  = TABLE_SLOTS * DIR_ENTRIES,
    localparam int unsigned TAB_AW     = $clog2(TAB_DEPTH)
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [IDX_W-1:0]  i_dir_waddr,
    input  t_dir_entry        i_dir_wdata,
    input  logic [IDX_W-1:0]  i_dir_raddr,
    output t_dir_entry        o_dir_rdata,
    input  logic [TAB_AW-1:0] i_tab_waddr,
    input  t_tab_entry        i_tab_wdata,
    input  logic [TAB_AW-1:0] i_tab_raddr,
    output t_tab_entry        o_tab_rdata
);

    t_dir_entry r_dir_mem [DIR_ENTRIES];
    t_tab_entry r_tab_mem [TAB_DEPTH];

    // Directory write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.dir_we) begin
            r_dir_mem[i_dir_waddr] <= i_dir_wdata;
        end
    end

    // Directory read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.dir_re) begin
            o_dir_rdata <= r_dir_mem[i_dir_raddr];
        end
    end

    // Table pool write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.tab_we) begin
            r_tab_mem[i_tab_waddr] <= i_tab_wdata;
        end
    end

    // Table pool read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.tab_re) begin
            o_tab_rdata <= r_tab_mem[i_tab_raddr];
        end
    end

endmodule

// ===== hdl/two_level_page_table_engine.sv =====
// Two-level page table engine: directory lookup, then table read or write.
// Result: registered straight from the directory read for map, unmap, the unused command
//   and a translate that misses; a translate that hits reads its table entry first, in S_TAB.
// Flow: a new request is taken only in S_IDLE, once the previous one has left S_DIR or S_TAB,
//   while its result may still wait; the directory and table reads are registered in tpte_store;
//   a result held by the receiver holds the engine. Depends on tpte_pkg, tpte_if, tpte_store.
// Reset: synchronous, active low; a clearing pass over all TABLE_SLOTS*1024 table entries
//   zeroes both memories before the first transaction is accepted.
module two_level_page_table_engine
    import tpte_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpte_req_if.sink    i_req,
    tpte_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam int unsigned TAB_DEPTH = TABLE_SLOTS * DIR_ENTRIES;
    localparam int unsigned TAB_AW    = $clog2(TAB_DEPTH);
    localparam int unsigned SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned CNT_W     = $clog2(TABLE_SLOTS + 1);

    t_state             r_state,     n_state;
    logic [TAB_AW-1:0]  r_clr_cnt,   n_clr_cnt;
    logic [CNT_W-1:0]   r_next_free, n_next_free;
    logic [FRAME_W-1:0] r_base,      n_base;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_out_frame, n_out_frame;
    t_status            r_out_status, n_out_status;
    logic [1:0]         r_cmd,       n_cmd;
    logic [IDX_W-1:0]   r_di,        n_di;
    logic [IDX_W-1:0]   r_ti,        n_ti;
    logic [FRAME_W-1:0] r_phys,      n_phys;
    logic               r_mark_exp,  n_mark_exp;

    t_mem_ctl           mem_ctl;
    logic [IDX_W-1:0]   dir_waddr, dir_raddr;
    t_dir_entry         dir_wdata, dir_rdata;
    logic [TAB_AW-1:0]  tab_waddr, tab_raddr;
    t_tab_entry         tab_wdata, tab_rdata;

    logic               accept;
    logic               can_load;
    logic [FRAME_W-1:0] diff;
    logic               hit;
    logic [SLOT_W-1:0]  hit_slot;
    logic               hit_mark;
    logic               pool_full;
    logic [SLOT_W-1:0]  new_slot;

    tpte_store #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_dir_waddr (dir_waddr),
        .i_dir_wdata (dir_wdata),
        .i_dir_raddr (dir_raddr),
        .o_dir_rdata (dir_rdata),
        .i_tab_waddr (tab_waddr),
        .i_tab_wdata (tab_wdata),
        .i_tab_raddr (tab_raddr),
        .o_tab_rdata (tab_rdata)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign accept           = i_req.valid && (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.phys_frame = r_out_frame;
    assign o_rsp.status     = r_out_status;
    assign can_load         = !r_out_valid || o_rsp.ready;

    // Slot named by the fetched directory entry, relative to the current base
    assign diff      = dir_rdata.addr - r_base;
    assign hit       = dir_rdata.present && (diff < FRAME_W'(TABLE_SLOTS));
    assign hit_slot  = diff[SLOT_W-1:0];
    // Slots are handed out in order, so a slot is allocated when below the count
    assign hit_mark  = (CNT_W'(hit_slot) < r_next_free);
    assign pool_full = (r_next_free == CNT_W'(TABLE_SLOTS));
    assign new_slot  = r_next_free[SLOT_W-1:0];

    // Next state, memory strobes and result
    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_next_free  = r_next_free;
        n_base       = i_cfg_we ? i_cfg_wdata[31:PAGE_SHIFT] : r_base;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_frame  = r_out_frame;
        n_out_status = r_out_status;
        n_cmd        = r_cmd;
        n_di         = r_di;
        n_ti         = r_ti;
        n_phys       = r_phys;
        n_mark_exp   = r_mark_exp;
        mem_ctl      = '0;
        dir_waddr    = r_di;
        dir_wdata    = '0;
        dir_raddr    = i_req.virt_addr[DIR_SHIFT +: IDX_W];
        tab_waddr    = TAB_AW'({hit_slot, r_ti});
        tab_wdata    = '0;
        tab_raddr    = TAB_AW'({hit_slot, r_ti});

        unique case (r_state)
            S_CLEAR: begin
                // Zero both memories, one entry per cycle
                mem_ctl.dir_we = 1'b1;
                mem_ctl.tab_we = 1'b1;
                dir_waddr      = r_clr_cnt[IDX_W-1:0];
                tab_waddr      = r_clr_cnt;
                n_clr_cnt      = r_clr_cnt + 1'b1;
                if (r_clr_cnt == TAB_AW'(TAB_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    mem_ctl.dir_re = 1'b1;
                    n_cmd          = i_req.command;
                    n_di           = i_req.virt_addr[DIR_SHIFT +: IDX_W];
                    n_ti           = i_req.virt_addr[PAGE_SHIFT +: IDX_W];
                    n_phys         = i_req.phys_addr[31:PAGE_SHIFT];
                    n_state        = S_DIR;
                end
            end
            S_DIR: begin
                if (r_cmd == CMD_XLATE && hit) begin
                    // Fetch the table entry; the result is registered in S_TAB once the output can load
                    mem_ctl.tab_re = 1'b1;
                    n_mark_exp     = hit_mark;
                    n_state        = S_TAB;
                end else if (can_load) begin
                    n_out_valid  = 1'b1;
                    n_out_frame  = '0;
                    n_out_status = ST_DONE;
                    n_state      = S_IDLE;
                    unique case (r_cmd)
                        CMD_MAP: begin
                            priority if (!dir_rdata.present) begin
                                if (pool_full) begin
                                    n_out_status = ST_NO_SLOT;
                                end else begin
                                    // Hand out the next slot; its old entries lose their mark
                                    mem_ctl.dir_we    = 1'b1;
                                    dir_wdata.present = 1'b1;
                                    dir_wdata.addr    = r_base + FRAME_W'(new_slot);
                                    mem_ctl.tab_we    = 1'b1;
                                    tab_waddr         = TAB_AW'({new_slot, r_ti});
                                    tab_wdata.mark    = 1'b1;
                                    tab_wdata.frame   = r_phys;
                                    n_next_free       = r_next_free + 1'b1;
                                end
                            end else if (hit) begin
                                mem_ctl.tab_we  = 1'b1;
                                tab_wdata.mark  = hit_mark;
                                tab_wdata.frame = r_phys;
                            end else begin
                                n_out_status = ST_NO_DIR;
                            end
                        end
                        CMD_UNMAP: begin
                            if (hit) begin
                                mem_ctl.tab_we = 1'b1;
                                tab_wdata.mark = hit_mark;
                            end else begin
                                n_out_status = ST_NO_DIR;
                            end
                        end
                        CMD_XLATE: begin
                            n_out_status = ST_NO_DIR;
                        end
                        default: begin
                            n_out_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_TAB: begin
                // An entry written under the other allocation mark reads as cleared
                if (can_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_DONE;
                    n_out_frame  = (tab_rdata.mark == r_mark_exp)
                                   ? {tab_rdata.frame, {PAGE_SHIFT{1'b0}}} : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_next_free <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_next_free <= n_next_free;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out_frame  <= n_out_frame;
        r_out_status <= n_out_status;
        r_cmd        <= n_cmd;
        r_di         <= n_di;
        r_ti         <= n_ti;
        r_phys       <= n_phys;
        r_mark_exp   <= n_mark_exp;
    end

endmodule

// ===== dv/tpte_walk_checker.sv =====
// Scoreboard for the two-level page table engine: watches the request, response
// and config ports, walks its own copy of the directory and tables, compares answers.
// Depends on tpte_pkg and the tpte_req_if / tpte_rsp_if interfaces.
`timescale 1ns / 100ps

module tpte_walk_checker
    import tpte_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tpte_req_if    i_req,
    tpte_rsp_if    i_rsp,
    input  logic   i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_checked,
    output int     o_no_dir,
    output int     o_no_slot
);

    localparam logic [31:0] FRAME_MASK   = 32'hFFFF_F000;
    localparam logic [31:0] PTE_PRESENT  = 32'h0000_0001;
    localparam logic [31:0] PTE_WRITABLE = 32'h0000_0002;
    localparam int unsigned TAB_ENTRIES  = 1 << IDX_W;

    typedef struct packed {
        logic [31:0] frame;
        logic [1:0]  status;
    } t_answer;

    // Shadow copy of the translation structures
    logic [31:0] dir_mem [DIR_ENTRIES];
    logic [31:0] tab_mem [TABLE_SLOTS * TAB_ENTRIES];
    int unsigned slots_used;
    logic [31:0] pool_base;

    t_answer     answer_q [$];
    t_answer     want;
    int          fail_count;
    int          checked;
    int          no_dir;
    int          no_slot;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;
    assign o_no_dir     = no_dir;
    assign o_no_slot    = no_slot;

    // One line per mismatch
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        fail_count++;
        $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, exp_val);
    endtask

    // Slot named by a directory entry under the current pool base; 0 if none
    function automatic bit table_slot(input logic [31:0] dent, output int unsigned slot);
        logic [31:0] diff;
        diff = ((dent & FRAME_MASK) - (pool_base & FRAME_MASK)) >> PAGE_SHIFT;
        slot = diff;
        return dent[0] && (diff < TABLE_SLOTS);
    endfunction

    // Apply one command to the shadow tables and return its answer
    function automatic t_answer walk_page_tables(input logic [1:0] cmd,
                                                 input logic [31:0] virt,
                                                 input logic [31:0] phys,
                                                 input logic [11:0] flags);
        logic [IDX_W-1:0] di;
        logic [IDX_W-1:0] ti;
        logic [31:0]      tbl_addr;
        int unsigned      slot;
        int unsigned      k;
        t_answer          ans;

        di         = virt[31:DIR_SHIFT];
        ti         = virt[DIR_SHIFT-1:PAGE_SHIFT];
        ans.frame  = '0;
        ans.status = ST_DONE;
        case (cmd)
            CMD_MAP: begin
                // absent directory entry: hand out the next slot, cleared
                if (!dir_mem[di][0]) begin
                    if (slots_used >= TABLE_SLOTS) begin
                        ans.status = ST_NO_SLOT;
                    end else begin
                        tbl_addr = (pool_base & FRAME_MASK) + (slots_used << PAGE_SHIFT);
                        for (k = 0; k < TAB_ENTRIES; k++)
                            tab_mem[slots_used * TAB_ENTRIES + k] = '0;
                        slots_used++;
                        dir_mem[di] = tbl_addr | PTE_PRESENT | PTE_WRITABLE | {20'b0, flags};
                    end
                end
                if (ans.status == ST_DONE) begin
                    if (table_slot(dir_mem[di], slot))
                        tab_mem[slot * TAB_ENTRIES + ti] =
                            (phys & FRAME_MASK) | PTE_PRESENT | {20'b0, flags};
                    else
                        ans.status = ST_NO_DIR;
                end
            end
            CMD_UNMAP: begin
                if (table_slot(dir_mem[di], slot))
                    tab_mem[slot * TAB_ENTRIES + ti] = '0;
                else
                    ans.status = ST_NO_DIR;
            end
            CMD_XLATE: begin
                if (table_slot(dir_mem[di], slot))
                    ans.frame = tab_mem[slot * TAB_ENTRIES + ti] & FRAME_MASK;
                else
                    ans.status = ST_NO_DIR;
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Retire responses, track the config register, predict accepted requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int unsigned d = 0; d < DIR_ENTRIES; d++)
                dir_mem[d] = '0;
            for (int unsigned e = 0; e < TABLE_SLOTS * TAB_ENTRIES; e++)
                tab_mem[e] = '0;
            slots_used = 0;
            pool_base  = '0;
            answer_q.delete();
            o_pending <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("response with no request outstanding",
                                    i_rsp.phys_frame, 32'h0);
                end else begin
                    want = answer_q.pop_front();
                    checked++;
                    if (want.status == ST_NO_DIR)
                        no_dir++;
                    if (want.status == ST_NO_SLOT)
                        no_slot++;
                    if (i_rsp.phys_frame !== want.frame)
                        report_mismatch("phys_frame", i_rsp.phys_frame, want.frame);
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", {30'b0, i_rsp.status}, {30'b0, want.status});
                end
            end
            if (i_cfg_we)
                pool_base = i_cfg_wdata;
            if (i_req.valid && i_req.ready)
                answer_q.push_back(walk_page_tables(i_req.command, i_req.virt_addr,
                                                    i_req.phys_addr, i_req.page_flags));
            o_pending <= answer_q.size();
        end
    end

endmodule

// ===== dv/two_level_page_table_engine_test.sv =====
// Top of the page table engine bench: clock, reset, request stimulus, response
// flow control, pool base writes and the verdict. Depends on tpte_pkg, the channel
// interfaces, the engine itself and tpte_walk_checker.
`timescale 1ns / 100ps

module two_level_page_table_engine_test
    import tpte_pkg::*;
();

    localparam logic [1:0]  CMD_NONE     = 2'd3;
    localparam logic [31:0] PAGE_BYTES   = 32'h0000_1000;
    localparam logic [31:0] BASE_TOP     = 32'hFFFF_F000;
    localparam logic [31:0] BASE_MID     = 32'h8000_0000;
    localparam int          RANDOM_ITEMS = 1600;
    localparam int          BLOCKS       = 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          TAIL_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    tpte_req_if req_ch ();
    tpte_rsp_if rsp_ch ();

    int          fail_count;
    int          pending;
    int          checked;
    int          no_dir;
    int          no_slot;
    int          idle_pct;
    int          stall_pct;
    int          hold_requests;
    int          hold_served;
    int          sent_items;
    int          directed_items;
    int          base_writes;
    int unsigned cycle_count;
    logic [9:0]  hot_dir [20];
    logic [9:0]  hot_tab [8];

    two_level_page_table_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    tpte_walk_checker walk_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_no_dir     (no_dir),
        .o_no_slot    (no_slot)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses still owed", cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Response side: random stalls, plus long hold-offs on request
    initial begin
        rsp_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_served) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served++;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it, until accepted
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] virt,
                             input logic [31:0] phys, input logic [11:0] flags);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.virt_addr  <= virt;
        req_ch.phys_addr  <= phys;
        req_ch.page_flags <= flags;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_items++;
    endtask

    // Stop offering and wait until every answer is back, then idle through a tail
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        base_writes++;
    endtask

    // Mostly addresses in a few hot directories and tables so maps get reused
    function automatic logic [31:0] pick_virt();
        logic [9:0] di;
        logic [9:0] ti;
        di = ($urandom_range(99) < 85) ? hot_dir[$urandom_range(19)] : 10'($urandom);
        ti = ($urandom_range(99) < 80) ? hot_tab[$urandom_range(7)] : 10'($urandom);
        return {di, ti, 12'($urandom)};
    endfunction

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return CMD_MAP;
        else if (r < 45)
            return CMD_UNMAP;
        else if (r < 95)
            return CMD_XLATE;
        return CMD_NONE;
    endfunction

    // Stimulus and verdict
    initial begin
        logic [31:0] base_val;
        logic [11:0] flags;

        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.command    <= CMD_MAP;
        req_ch.virt_addr  <= '0;
        req_ch.phys_addr  <= '0;
        req_ch.page_flags <= '0;
        idle_pct          = 0;
        stall_pct         = 0;

        hot_dir[0] = 10'd0;
        hot_dir[1] = 10'd1023;
        hot_dir[2] = 10'd5;
        for (int i = 3; i < 20; i++)
            hot_dir[i] = 10'($urandom);
        hot_tab[0] = 10'd0;
        hot_tab[1] = 10'd1023;
        for (int i = 2; i < 8; i++)
            hot_tab[i] = 10'($urandom);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: absent entries, extremes, reuse of a present directory entry,
        // unmap then translate, the unused command
        write_base('0);
        send_item(CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
        send_item(CMD_UNMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        send_item(CMD_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        send_item(CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
        send_item(CMD_MAP,   32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
        send_item(CMD_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        send_item(CMD_MAP,   32'h003F_F000, 32'h1234_5678, 12'h5A5);
        send_item(CMD_XLATE, 32'h003F_FABC, 32'h0000_0000, 12'h000);
        send_item(CMD_UNMAP, 32'h0000_0000, 32'h0000_0000, 12'h000);
        send_item(CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
        send_item(CMD_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        send_item(CMD_NONE,  32'h0000_0000, 32'h0000_0000, 12'h000);

        // Top base: old entries alias onto other slots, new slot wraps around
        write_base(BASE_TOP);
        send_item(CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
        send_item(CMD_MAP,   32'h0140_0000, 32'hA5A5_A5A5, 12'h3C3);
        send_item(CMD_XLATE, 32'h0140_0FFF, 32'h0000_0000, 12'h000);

        // Far base: existing entries go stale
        write_base(BASE_MID);
        send_item(CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
        send_item(CMD_MAP,   32'h0000_0000, 32'h5555_5000, 12'h0F0);
        send_item(CMD_UNMAP, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
        directed_items = sent_items;

        // Random blocks, each with its own base and flow-control mix
        for (int b = 0; b < BLOCKS; b++) begin
            case (b)
                1:       base_val = BASE_TOP;
                3:       base_val = PAGE_BYTES * 2;
                5:       base_val = $urandom_range(32'hFFFF_E000) | 32'h0000_0FFF;
                7:       base_val = BASE_MID;
                default: base_val = '0;
            endcase
            write_base(base_val);
            case (b % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 64; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            // long response hold-off while requests keep coming
            if (b % 4 == 0)
                hold_requests++;
            for (int n = 0; n < RANDOM_ITEMS / BLOCKS; n++) begin
                case ($urandom_range(9))
                    0:       flags = 12'h000;
                    1:       flags = 12'hFFF;
                    default: flags = 12'($urandom);
                endcase
                send_item(pick_cmd(), pick_virt(), $urandom, flags);
            end
        end

        settle();
        $display("Run covered %0d requests (%0d directed) over %0d pool base settings,",
                 sent_items, directed_items, base_writes);
        $display("four flow-control mixes; %0d answers checked, %0d no-directory, %0d pool-out.",
                 checked, no_dir, no_slot);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
